// ===== rtl/nfcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NFC response frame parser package
// Shared types, frame constants and result codes.
// ----------------------------------------------------------------------------
package nfcp_pkg;

    localparam logic [7:0] STATUS_READY = 8'h01;
    localparam logic [7:0] START_ZERO   = 8'h00;
    localparam logic [7:0] START_END    = 8'hFF;
    localparam logic [7:0] FRAME_TFI    = 8'hD5;

    // Configuration register indexes.
    localparam logic REG_EXP_CMD  = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    // Result codes.
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_NOT_READY = 3'd1;
    localparam logic [2:0] ERR_START     = 3'd2;
    localparam logic [2:0] ERR_LCS       = 3'd3;
    localparam logic [2:0] ERR_TFI       = 3'd4;
    localparam logic [2:0] ERR_RESPONSE  = 3'd5;
    localparam logic [2:0] ERR_SHORT     = 3'd6;
    localparam logic [2:0] ERR_LONG      = 3'd7;

    typedef enum logic [9:0] {
        PH_IDLE    = 10'b00_0000_0001,
        PH_SC0     = 10'b00_0000_0010,
        PH_SC1     = 10'b00_0000_0100,
        PH_SC2     = 10'b00_0000_1000,
        PH_LEN     = 10'b00_0001_0000,
        PH_LCS     = 10'b00_0010_0000,
        PH_TFI     = 10'b00_0100_0000,
        PH_CMD     = 10'b00_1000_0000,
        PH_PAYLOAD = 10'b01_0000_0000,
        PH_DONE    = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       start_req;
    } t_item;

endpackage

// ===== rtl/nfc_response_frame_parser.sv =====
`timescale 1ns / 1ps
// An accepted byte is registered in the skid buffer, then its result at m_axis_tvalid.
// Throughput: one byte per cycle unless the output stalls; one FSM step handles each byte.
// The input skid buffer keeps s_axis_tready registered while the output register stalls.
// Reset (i_rst_n low, synchronous) returns to idle, clears both buffers and sets
// expected_command to 0 and payload_capacity to 255.
// ----------------------------------------------------------------------------
// NFC response frame parser
// Checks a streamed response frame byte by byte and emits its payload bytes.
// ----------------------------------------------------------------------------
module nfc_response_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] payload_index
    output logic        m_axis_tlast,   // last
    output logic [3:0]  m_axis_tuser    // [0] no_payload, [3:1] error_code
);
    import nfcp_pkg::*;

    t_item      in_item;
    t_item      core_item;
    logic       core_valid;
    logic       pop_en;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       no_payload;
    logic [2:0] error_code;

    assign in_item.rx_byte   = s_axis_tdata;
    assign in_item.start_req = s_axis_tuser;

    nfcp_in_skid u_in_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_item   (in_item),
        .o_valid  (core_valid),
        .i_pop_en (pop_en),
        .o_item   (core_item)
    );

    nfcp_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_item_valid    (core_valid),
        .i_item          (core_item),
        .o_pop_en        (pop_en),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_payload_byte  (payload_byte),
        .o_payload_index (payload_index),
        .o_no_payload    (no_payload),
        .o_last          (m_axis_tlast),
        .o_error_code    (error_code)
    );

    assign m_axis_tdata = {payload_index, payload_byte};
    assign m_axis_tuser = {error_code, no_payload};

endmodule

// ===== rtl/nfcp_in_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NFC response frame parser input stage
// Two-entry skid buffer; ready toward the source comes straight from a flop.
// ----------------------------------------------------------------------------
module nfcp_in_skid (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  nfcp_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_pop_en,
    output nfcp_pkg::t_item o_item
);
    import nfcp_pkg::*;

    logic  r_main_valid;
    logic  r_skid_valid;
    t_item r_main;
    t_item r_skid;
    logic  accept;
    logic  main_free;

    assign accept    = i_valid && !r_skid_valid;
    assign main_free = !r_main_valid || i_pop_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (main_free) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (main_free) begin
            r_main <= r_skid_valid ? r_skid : i_item;
        end
        if (!main_free && accept) begin
            r_skid <= i_item;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_item  = r_main;

endmodule

// ===== rtl/nfcp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NFC response frame parser core
// Frame state machine, configuration registers and the result register.
// ----------------------------------------------------------------------------
module nfcp_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_addr,
    input  logic [7:0]      i_cfg_wdata,
    input  logic            i_item_valid,
    input  nfcp_pkg::t_item i_item,
    output logic            o_pop_en,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_payload_byte,
    output logic [7:0]      o_payload_index,
    output logic            o_no_payload,
    output logic            o_last,
    output logic [2:0]      o_error_code
);
    import nfcp_pkg::*;

    logic [7:0] r_exp_cmd;
    logic [7:0] r_capacity;
    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_len;
    logic [7:0] n_len;
    logic [7:0] r_count;
    logic [7:0] n_count;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic [7:0] r_out_index;
    logic       r_out_nop;
    logic       r_out_last;
    logic [2:0] r_out_err;

    logic       out_free;
    logic       consume;
    logic       fail;
    logic [2:0] fail_err;
    logic       res_valid;
    logic [7:0] res_byte;
    logic [7:0] res_index;
    logic       res_nop;
    logic       res_last;
    logic [2:0] res_err;
    logic [7:0] plen;
    logic [7:0] resp_code;
    logic       pay_last;

    assign out_free  = !r_out_valid || i_out_ready;
    assign consume   = i_item_valid && out_free;
    assign plen      = r_len - 8'd2;
    assign resp_code = r_exp_cmd + 8'd1;
    assign pay_last  = ({1'b0, r_count} + 9'd1) >= {1'b0, plen};

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_count   = r_count;
        fail      = 1'b0;
        fail_err  = ERR_OK;
        res_valid = 1'b0;
        res_byte  = 8'd0;
        res_index = 8'd0;
        res_nop   = 1'b0;
        res_last  = 1'b0;
        res_err   = ERR_OK;
        if (i_item.start_req) begin
            n_len   = 8'd0;
            n_count = 8'd0;
            if (i_item.rx_byte != STATUS_READY) begin
                fail     = 1'b1;
                fail_err = ERR_NOT_READY;
            end else begin
                n_phase = PH_SC0;
            end
        end else begin
            unique case (r_phase)
                PH_SC0: begin
                    if (i_item.rx_byte != START_ZERO) begin
                        fail     = 1'b1;
                        fail_err = ERR_START;
                    end else begin
                        n_phase = PH_SC1;
                    end
                end
                PH_SC1: begin
                    if (i_item.rx_byte != START_ZERO) begin
                        fail     = 1'b1;
                        fail_err = ERR_START;
                    end else begin
                        n_phase = PH_SC2;
                    end
                end
                PH_SC2: begin
                    if (i_item.rx_byte != START_END) begin
                        fail     = 1'b1;
                        fail_err = ERR_START;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_len   = i_item.rx_byte;
                    n_phase = PH_LCS;
                end
                PH_LCS: begin
                    if ((r_len + i_item.rx_byte) != 8'd0) begin
                        fail     = 1'b1;
                        fail_err = ERR_LCS;
                    end else begin
                        n_phase = PH_TFI;
                    end
                end
                PH_TFI: begin
                    if (i_item.rx_byte != FRAME_TFI) begin
                        fail     = 1'b1;
                        fail_err = ERR_TFI;
                    end else begin
                        n_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    // Checks are ordered: response code, then length bounds.
                    if (i_item.rx_byte != resp_code) begin
                        fail     = 1'b1;
                        fail_err = ERR_RESPONSE;
                    end else if (r_len < 8'd2) begin
                        fail     = 1'b1;
                        fail_err = ERR_SHORT;
                    end else if (plen > r_capacity) begin
                        fail     = 1'b1;
                        fail_err = ERR_LONG;
                    end else if (plen == 8'd0) begin
                        n_phase   = PH_DONE;
                        res_valid = 1'b1;
                        res_nop   = 1'b1;
                        res_last  = 1'b1;
                    end else begin
                        n_count = 8'd0;
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    res_valid = 1'b1;
                    res_byte  = i_item.rx_byte;
                    res_index = r_count;
                    res_last  = pay_last;
                    n_count   = r_count + 8'd1;
                    if (pay_last) begin
                        n_phase = PH_DONE;
                    end
                end
                default: ;
            endcase
        end
        if (fail) begin
            n_phase   = PH_DONE;
            res_valid = 1'b1;
            res_last  = 1'b1;
            res_err   = fail_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_cmd  <= 8'd0;
            r_capacity <= 8'd255;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_EXP_CMD:  r_exp_cmd  <= i_cfg_wdata;
                REG_CAPACITY: r_capacity <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= 8'd0;
            r_count <= 8'd0;
        end else if (consume) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && res_valid) begin
            r_out_byte  <= res_byte;
            r_out_index <= res_index;
            r_out_nop   <= res_nop;
            r_out_last  <= res_last;
            r_out_err   <= res_err;
        end
    end

    assign o_pop_en        = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_payload_byte  = r_out_byte;
    assign o_payload_index = r_out_index;
    assign o_no_payload    = r_out_nop;
    assign o_last          = r_out_last;
    assign o_error_code    = r_out_err;

`ifndef SYNTHESIS
    a_err_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err != ERR_OK) |-> (r_out_last && r_out_byte == 8'd0))
        else $error("error result not marked final or carries a byte");

    a_empty_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_nop) |-> (r_out_last && r_out_err == ERR_OK))
        else $error("empty-payload result malformed");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && res_valid && res_last) |=> (r_phase == PH_DONE))
        else $error("frame did not end after its final result");
`endif

endmodule

// ===== verif/tb_nfc_response_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NFC response frame parser testbench
// Streams status/start-code/length/identifier/response frames into the parser,
// good ones and faulted ones, with random stalls on both sides. Each accepted
// byte runs through a local parser model and every result item is compared
// with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_nfc_response_frame_parser;
    import nfcp_pkg::*;

    typedef struct packed {
        logic [7:0] pbyte;
        logic [7:0] pidx;
        logic       nopl;
        logic       lst;
        logic [2:0] err;
    } t_frame_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        s_axis_tuser;   // [0] start_req
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] payload_byte, [15:8] payload_index
    logic        m_axis_tlast;   // last
    logic [3:0]  m_axis_tuser;   // [0] no_payload, [3:1] error_code

    nfc_response_frame_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_item      rx_queue[$];
    t_frame_res frame_results[$];
    t_item      next_item;
    logic       in_fire;
    logic       hold_rx;
    logic       pressure_go;
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         n_fail;
    int         live_items;
    logic [7:0] cur_cmd;
    logic [7:0] cur_cap;

    // Local copy of the parser state and registers.
    t_phase     frame_phase;
    logic [7:0] frame_len;
    logic [7:0] payload_cnt;
    logic [7:0] cfg_cmd;
    logic [7:0] cfg_capacity;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic reject(input logic [2:0] code, inout t_frame_res r, inout logic hit);
        frame_phase = PH_DONE;
        r.err = code;
        r.lst = 1'b1;
        hit = 1'b1;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b, input logic st);
        t_frame_res r;
        logic       hit;
        logic [7:0] sum;
        logic [7:0] want_resp;
        logic [7:0] plen;
        r = '0;
        hit = 1'b0;
        if (st) begin
            frame_len = 8'd0;
            payload_cnt = 8'd0;
            if (b != STATUS_READY) reject(ERR_NOT_READY, r, hit);
            else frame_phase = PH_SC0;
        end else begin
            case (frame_phase)
                PH_SC0, PH_SC1: begin
                    if (b != START_ZERO) reject(ERR_START, r, hit);
                    else if (frame_phase == PH_SC0) frame_phase = PH_SC1;
                    else frame_phase = PH_SC2;
                end
                PH_SC2: begin
                    if (b != START_END) reject(ERR_START, r, hit);
                    else frame_phase = PH_LEN;
                end
                PH_LEN: begin
                    frame_len = b;
                    frame_phase = PH_LCS;
                end
                PH_LCS: begin
                    sum = frame_len + b;
                    if (sum != 8'd0) reject(ERR_LCS, r, hit);
                    else frame_phase = PH_TFI;
                end
                PH_TFI: begin
                    if (b != FRAME_TFI) reject(ERR_TFI, r, hit);
                    else frame_phase = PH_CMD;
                end
                PH_CMD: begin
                    want_resp = cfg_cmd + 8'd1;
                    plen = frame_len - 8'd2;
                    if (b != want_resp) reject(ERR_RESPONSE, r, hit);
                    else if (frame_len < 8'd2) reject(ERR_SHORT, r, hit);
                    else if (plen > cfg_capacity) reject(ERR_LONG, r, hit);
                    else if (plen == 8'd0) begin
                        frame_phase = PH_DONE;
                        r.nopl = 1'b1;
                        r.lst = 1'b1;
                        hit = 1'b1;
                    end else begin
                        payload_cnt = 8'd0;
                        frame_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    plen = frame_len - 8'd2;
                    r.pbyte = b;
                    r.pidx = payload_cnt;
                    r.lst = ({1'b0, payload_cnt} + 9'd1) >= {1'b0, plen};
                    hit = 1'b1;
                    payload_cnt = payload_cnt + 8'd1;
                    if (r.lst) frame_phase = PH_DONE;
                end
                default: ;
            endcase
        end
        if (hit) frame_results.push_back(r);
    endtask

    // Monitor: checks result items, mirrors register writes, predicts per byte.
    always @(posedge i_clk) begin
        t_frame_res got;
        t_frame_res want;
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            frame_phase = PH_IDLE;
            frame_len = 8'd0;
            payload_cnt = 8'd0;
            cfg_cmd = 8'd0;
            cfg_capacity = 8'd255;
            frame_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.pbyte = m_axis_tdata[7:0];
                got.pidx = m_axis_tdata[15:8];
                got.nopl = m_axis_tuser[0];
                got.lst = m_axis_tlast;
                got.err = m_axis_tuser[3:1];
                if (frame_results.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected result, expected none, got byte=%h idx=%0d",
                             $time, got.pbyte, got.pidx);
                end else begin
                    want = frame_results.pop_front();
                    if (got !== want) begin
                        n_fail++;
                        $display("%0t: expected byte=%h idx=%0d nopl=%b last=%b err=%0d",
                                 $time, want.pbyte, want.pidx, want.nopl, want.lst, want.err);
                        $display("%0t:   actual byte=%h idx=%0d nopl=%b last=%b err=%0d",
                                 $time, got.pbyte, got.pidx, got.nopl, got.lst, got.err);
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_EXP_CMD) cfg_cmd = i_cfg_wdata;
                else cfg_capacity = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) parse_rx_byte(s_axis_tdata, s_axis_tuser);
        end
    end

    // Sender: presents the next queued item once the current one is taken.
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || in_fire) begin
            if (rx_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_item = rx_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= next_item.rx_byte;
                s_axis_tuser <= next_item.start_req;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
    end

    // Long receiver hold-off so that the parser backs up into its input.
    initial begin
        hold_rx = 1'b0;
        wait (pressure_go);
        @(negedge i_clk);
        hold_rx <= 1'b1;
        repeat (400) @(negedge i_clk);
        hold_rx <= 1'b0;
    end

    task automatic write_reg(input logic addr, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] cmd, input logic [7:0] cap);
        cur_cmd = cmd;
        cur_cap = cap;
        write_reg(REG_EXP_CMD, cmd);
        write_reg(REG_CAPACITY, cap);
    endtask

    task automatic push_rx(input logic [7:0] b, input logic st);
        t_item it;
        it.rx_byte = b;
        it.start_req = st;
        rx_queue.push_back(it);
    endtask

    function automatic logic [7:0] other_than(input logic [7:0] v);
        logic [7:0] d;
        d = 8'($urandom_range(1, 255));
        return v + d;
    endfunction

    // Builds one frame; fault selects the check that is broken (0 for none),
    // cut drops the tail so that the next start interrupts the frame.
    task automatic add_frame(input int plen, input int fault, input bit cut);
        logic [7:0] fr[$];
        logic [7:0] len;
        int         n_live;
        int         pos;
        int         n_tail;
        int         k;
        fr.delete();
        if (fault == ERR_SHORT) len = 8'($urandom_range(1));
        else len = 8'(plen + 2);
        fr.push_back(STATUS_READY);
        fr.push_back(START_ZERO);
        fr.push_back(START_ZERO);
        fr.push_back(START_END);
        fr.push_back(len);
        fr.push_back(8'h00 - len);
        fr.push_back(FRAME_TFI);
        fr.push_back(cur_cmd + 8'd1);
        n_live = 8;
        if (fault == ERR_OK) begin
            for (k = 0; k < plen; k++) fr.push_back(8'($urandom_range(255)));
            n_live += plen;
        end else begin
            n_tail = $urandom_range(3);
            for (k = 0; k < n_tail; k++) fr.push_back(8'($urandom_range(255)));
        end
        // Data checksum and postamble are passed through unchecked.
        fr.push_back(8'($urandom_range(255)));
        fr.push_back(START_ZERO);
        case (fault)
            ERR_NOT_READY: begin
                fr[0] = other_than(STATUS_READY);
                n_live = 1;
            end
            ERR_START: begin
                pos = $urandom_range(1, 3);
                fr[pos] = other_than(fr[pos]);
                n_live = pos + 1;
            end
            ERR_LCS: begin
                fr[5] = other_than(fr[5]);
                n_live = 6;
            end
            ERR_TFI: begin
                fr[6] = other_than(fr[6]);
                n_live = 7;
            end
            ERR_RESPONSE: fr[7] = other_than(fr[7]);
            default: ;
        endcase
        if (cut) begin
            pos = $urandom_range(1, fr.size() - 1);
            fr = fr[0:pos-1];
            if (pos < n_live) n_live = pos;
        end
        for (k = 0; k < fr.size(); k++) push_rx(fr[k], k == 0);
        live_items += n_live;
    endtask

    task automatic drain;
        do @(posedge i_clk);
        while (rx_queue.size() != 0 || s_axis_tvalid || frame_results.size() != 0);
        // Bytes that give no result may still sit in the pipeline.
        repeat (10) @(negedge i_clk);
    endtask

    task automatic run_random(input logic [7:0] cmd, input logic [7:0] cap, input int target);
        int r;
        int fault;
        int pmax;
        int plen;
        set_config(cmd, cap);
        live_items = 0;
        while (live_items < target) begin
            r = $urandom_range(99);
            if (r < 8) begin
                push_rx(8'($urandom_range(255)), 1'b0);
            end else if (r < 11) begin
                push_rx(8'($urandom_range(255)), 1'b1);
                live_items++;
            end else begin
                fault = ($urandom_range(99) < 72) ? ERR_OK : $urandom_range(1, 7);
                if (fault == ERR_LONG && cap >= 8'd253) fault = ERR_OK;
                pmax = (cap < 8'd253) ? cap : 253;
                if (fault == ERR_LONG) plen = $urandom_range(cap + 1, 253);
                else if ($urandom_range(19) == 0) plen = $urandom_range(pmax);
                else plen = $urandom_range((pmax < 6) ? pmax : 6);
                add_frame(plen, fault, $urandom_range(19) == 0);
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_EXP_CMD;
        i_cfg_wdata = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        in_fire = 1'b0;
        pressure_go = 1'b0;
        n_fail = 0;
        live_items = 0;
        cur_cmd = 8'd0;
        cur_cap = 8'd255;
        tx_idle_pct = 6;
        rx_idle_pct = 81;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames on the reset register values.
        add_frame(0, ERR_OK, 1'b0);
        add_frame(1, ERR_OK, 1'b0);
        add_frame(3, ERR_OK, 1'b0);
        add_frame(0, ERR_NOT_READY, 1'b0);
        add_frame(0, ERR_START, 1'b0);
        add_frame(0, ERR_LCS, 1'b0);
        add_frame(0, ERR_TFI, 1'b0);
        add_frame(0, ERR_RESPONSE, 1'b0);
        add_frame(0, ERR_SHORT, 1'b0);
        push_rx(8'hFF, 1'b0);
        add_frame(2, ERR_OK, 1'b1);
        add_frame(2, ERR_OK, 1'b0);
        drain();

        // Response code wraps to zero; capacity at its bound and one above.
        set_config(8'hFF, 8'd2);
        add_frame(2, ERR_OK, 1'b0);
        add_frame(3, ERR_LONG, 1'b0);
        add_frame(0, ERR_OK, 1'b0);
        drain();

        run_random(8'($urandom_range(255)), 8'($urandom_range(20)), 90);
        run_random(8'hFF, 8'd0, 65);

        tx_idle_pct = 81;
        rx_idle_pct = 6;
        run_random(8'($urandom_range(255)), 8'd255, 95);
        run_random(8'h00, 8'($urandom_range(255)), 90);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        pressure_go = 1'b1;
        run_random(8'($urandom_range(255)), 8'd8, 100);
        run_random(8'h7E, 8'd253, 100);

        if (n_fail == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
